>>> hdl/urid_pkg.sv
// ----------------------------------------------------------------------------
// urid_pkg
// Shared types, character constants and hex helpers for the URI percent
// decoder.
// ----------------------------------------------------------------------------
package urid_pkg;

    localparam logic [7:0] PCT_CHAR  = 8'h25;
    localparam logic [7:0] ZERO_CHAR = 8'h30;

    // Largest number of output bytes one input byte can cause.
    localparam int unsigned MAX_OUT = 3;
    localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_OUT);

    // One group of output bytes caused by a single input beat.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] data;   // data[0] goes out first
        logic [CNT_W-1:0]        count;  // 1 to MAX_OUT bytes valid
        logic                    last;   // group closes the string
    } entry_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h41) && (c <= 8'h46)) ||
            ((c >= 8'h61) && (c <= 8'h66));
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = c - 8'h30;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = c - 8'h37;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

>>> hdl/uri_percent_decoder.sv
// ----------------------------------------------------------------------------
// uri_percent_decoder
// Streaming URI percent decoder: '%' plus two hex digits becomes one byte,
// '%00' and broken escapes pass through literally, open escapes are flushed
// on the final byte.
//
//   Channel | Direction | tdata          | tlast
//   s_      | in        | [7:0] in_byte  | in_last
//   m_      | out       | [7:0] out_byte | out_last
//
// One input beat is taken per cycle while the group queue has room; the
// output side sends one byte per cycle while m_tready is high, and a byte
// that causes two or three outputs is absorbed by the QUEUE_DEPTH-entry
// queue. A group is written into the queue and then loaded into the
// serializer register before its first output beat.
// Reset is synchronous and active low; it clears the escape state and empties
// the queue. Either side may stall independently.
// ----------------------------------------------------------------------------
module uri_percent_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import urid_pkg::*;

    logic   in_fire;
    logic   push;
    entry_t push_entry;
    logic   full;
    logic   pop;
    logic   head_valid;
    entry_t head_entry;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    urid_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    urid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    urid_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> hdl/urid_front.sv
// ----------------------------------------------------------------------------
// urid_front
// Escape tracker: classifies each input byte against the pending escape and
// builds the group of output bytes it causes.
// ----------------------------------------------------------------------------
module urid_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output logic            push,
    output urid_pkg::entry_t push_entry
);
    import urid_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HEX  = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    entry_t           grp;
    logic [IDX_W-1:0] n;
    logic [CNT_W-1:0] cnt;

    always_comb begin
        grp        = '0;
        n          = '0;
        cnt        = '0;
        phase_next = phase_reg;
        held_next  = held_reg;

        case (phase_reg)
            PH_PCT: begin
                if (is_hex(in_byte)) begin
                    held_next  = in_byte;
                    phase_next = PH_HEX;
                end else begin
                    grp.data[n] = PCT_CHAR;
                    n = n + 1'b1;
                    cnt = cnt + 1'b1;
                    if (in_byte == PCT_CHAR) begin
                        phase_next = PH_PCT;
                    end else begin
                        grp.data[n] = in_byte;
                        n = n + 1'b1;
                        cnt = cnt + 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_HEX: begin
                if (is_hex(in_byte)) begin
                    if ((held_reg == ZERO_CHAR) && (in_byte == ZERO_CHAR)) begin
                        // The null escape is passed through as three bytes.
                        grp.data[0] = PCT_CHAR;
                        grp.data[1] = ZERO_CHAR;
                        grp.data[2] = ZERO_CHAR;
                        cnt = CNT_W'(3);
                    end else begin
                        grp.data[0] = {hex_val(held_reg), hex_val(in_byte)};
                        cnt = CNT_W'(1);
                    end
                    phase_next = PH_IDLE;
                end else begin
                    grp.data[0] = PCT_CHAR;
                    grp.data[1] = held_reg;
                    n = IDX_W'(2);
                    cnt = CNT_W'(2);
                    if (in_byte == PCT_CHAR) begin
                        phase_next = PH_PCT;
                    end else begin
                        grp.data[n] = in_byte;
                        n = n + 1'b1;
                        cnt = cnt + 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: begin
                if (in_byte == PCT_CHAR) begin
                    phase_next = PH_PCT;
                end else begin
                    grp.data[n] = in_byte;
                    n = n + 1'b1;
                    cnt = cnt + 1'b1;
                    phase_next = PH_IDLE;
                end
            end
        endcase

        // On the final byte, whatever escape is still open is flushed literally.
        if (in_last) begin
            if (phase_next == PH_PCT) begin
                grp.data[n] = PCT_CHAR;
                cnt = cnt + 1'b1;
            end else if (phase_next == PH_HEX) begin
                grp.data[n] = PCT_CHAR;
                n = n + 1'b1;
                grp.data[n] = held_next;
                cnt = cnt + CNT_W'(2);
            end
            phase_next = PH_IDLE;
        end

        grp.count = cnt;
        grp.last  = in_last;
    end

    assign push       = in_fire && (cnt != '0);
    assign push_entry = grp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (in_fire) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            held_reg <= held_next;
        end
    end

    // A final byte always produces at least one output byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_last) |-> push)
        else $error("final byte produced no output");

    // After a final byte the tracker is back to no pending escape.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_last) |=> (phase_reg == PH_IDLE))
        else $error("escape left open after final byte");

endmodule

>>> hdl/urid_queue.sv
// ----------------------------------------------------------------------------
// urid_queue
// Short FIFO of output groups between the escape tracker and the serializer.
// ----------------------------------------------------------------------------
module urid_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  urid_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output urid_pkg::entry_t head_entry
);
    import urid_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    entry_t        mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) !(push && full))
        else $error("queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn) !(pop && !head_valid))
        else $error("queue underflow");

endmodule

>>> hdl/urid_back.sv
// ----------------------------------------------------------------------------
// urid_back
// Serializer: takes one output group at a time from the queue and sends its
// bytes out one beat each.
// ----------------------------------------------------------------------------
module urid_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  urid_pkg::entry_t head_entry,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import urid_pkg::*;

    entry_t           cur_reg;
    logic             cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             at_end;
    logic             fire;

    assign at_end = (CNT_W'(idx_reg) == (cur_reg.count - 1'b1));
    assign fire   = cur_valid_reg && m_tready;
    assign pop    = head_valid && (!cur_valid_reg || (fire && at_end));

    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (fire) begin
            if (at_end) begin
                cur_valid_next = 1'b0;
                idx_next       = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head_entry;
        end
    end

    assign m_tvalid = cur_valid_reg;
    assign m_tdata  = cur_reg.data[idx_reg];
    assign m_tlast  = cur_reg.last && at_end;

    // The byte pointer never runs past the group it walks through.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> ((cur_reg.count != '0) && (CNT_W'(idx_reg) < cur_reg.count)))
        else $error("byte index outside current group");

endmodule
